// ===== rtl/first_fit_free_list_allocator_macros.svh =====
// Assertion helpers for the allocator checker
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Implication checked on every clock edge outside reset
`define FFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal stays stable while a condition holds over an edge
`define FFA_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    cond |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 9;

  typedef enum logic [0:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] len;
  } region_t;

  typedef struct packed {
    logic            [0:0] cmd;
    logic [AddrW-1:0] block_addr;
    logic [AddrW-1:0] block_size;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0]  alloc_addr;
    logic [1:0]        status;
    logic [AddrW-1:0]  total_free;
    logic [CountW-1:0] region_count;
    logic [CountW-1:0] peak_count;
    logic [AddrW-1:0]  lost_count;
    logic [AddrW-1:0]  lost_bytes;
  } rsp_t;

endpackage

// ===== rtl/ffa_if.sv =====
interface ffa_req_if import ffa_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ffa_cell.sv =====
module ffa_cell import ffa_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  region_t val_i,
  output region_t val_o
);
  region_t val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_i;
    end
  end

  assign val_o = val_q;
endmodule

// ===== rtl/ffa_row.sv =====
// Chain of cells. On shift every entry moves one place toward the head and the
// tail cell takes the new value; a full lap brings each written value into place.
module ffa_row import ffa_pkg::*; #(
  parameter int unsigned Depth = 256
) (
  input  logic    clk_i,
  input  logic    shift_i,
  input  region_t tail_i,
  output region_t head_o,
  output region_t next_o
);
  region_t link [Depth+1];

  assign link[Depth] = tail_i;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    ffa_cell u_cell (
      .clk_i (clk_i),
      .en_i  (shift_i),
      .val_i (link[g+1]),
      .val_o (link[g])
    );
  end

  assign head_o = link[0];
  assign next_o = link[1];
endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// Sequence: an accepted input item moves to the scan state, where the cell row makes one
// full lap, one entry a cycle, whatever the entry count; then the result item is valid.
// Flow: the input is open only while idle, so a new item is taken only after the last result;
// a waiting result holds the input off until it is taken.
// Reset: counters, totals and the entry count clear at once; cells are not cleared and
// only entries below the count are ever read.
module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE, S_SCAN, S_OUT
  } state_e;

  // What the tail takes for the rest of the lap
  typedef enum logic [1:0] {
    M_COPY, M_LEFT, M_RIGHT, M_REPL
  } mode_e;

  state_e           state_q;
  mode_e            mode_q, mode_d;
  req_t             req_q;
  logic [IdxW-1:0]  step_q, n_q, used_q, used_d, peak_q, peak_d;
  logic [IdxW-1:0]  step_nxt, used_inc;
  logic [AddrW-1:0] sum_q, sum_d, lost_n_q, lost_n_d, lost_b_q, lost_b_d, addr_q, addr_d;
  logic [AddrW-1:0] rel_end;
  status_e          status_q, status_d;
  logic             done_q, done_d;
  region_t          dly_q, dly_d;
  region_t          head, second, tail, fresh;
  logic             shift, cur_v, next_v, full, at_first, at_before;

  ffa_row #(.Depth(TABLE_ENTRIES)) u_row (
    .clk_i   (clk_i),
    .shift_i (shift),
    .tail_i  (tail),
    .head_o  (head),
    .next_o  (second)
  );

  assign shift    = state_q == S_SCAN;
  assign step_nxt = step_q + IdxW'(1);
  assign used_inc = used_q + IdxW'(1);
  assign cur_v    = step_q < n_q;
  assign next_v   = step_nxt < n_q;
  assign full     = n_q == IdxW'(TABLE_ENTRIES);
  assign rel_end  = req_q.block_addr + req_q.block_size;
  assign fresh    = {req_q.block_addr, req_q.block_size};

  // Release goes in front of every entry
  assign at_first = (step_q == '0) && (cur_v ? (head.start > req_q.block_addr) : 1'b1);
  // Head is the last entry starting at or below the released address
  assign at_before = cur_v && (head.start <= req_q.block_addr)
                     && (next_v ? (second.start > req_q.block_addr) : 1'b1);

  always_comb begin
    tail     = head;
    dly_d    = head;
    mode_d   = mode_q;
    done_d   = done_q;
    addr_d   = addr_q;
    status_d = status_q;
    sum_d    = sum_q;
    used_d   = used_q;
    peak_d   = peak_q;
    lost_n_d = lost_n_q;
    lost_b_d = lost_b_q;
    case (mode_q)
      M_LEFT: begin
        tail = second;
      end
      M_RIGHT: begin
        tail = dly_q;
      end
      M_REPL: begin
        tail   = dly_q;
        mode_d = M_COPY;
      end
      default: begin
        if (!done_q) begin
          if (req_q.cmd == CMD_ALLOC) begin
            if (cur_v && (head.len >= req_q.block_size)) begin
              done_d     = 1'b1;
              addr_d     = head.start;
              status_d   = ST_OK;
              sum_d      = sum_q - req_q.block_size;
              tail.start = head.start + req_q.block_size;
              tail.len   = head.len - req_q.block_size;
              if (head.len == req_q.block_size) begin
                // Entry used up: close the gap
                tail   = second;
                mode_d = M_LEFT;
                used_d = used_q - IdxW'(1);
              end
            end
          end else if (at_first) begin
            done_d = 1'b1;
            if (cur_v && (rel_end == head.start)) begin
              tail.start = req_q.block_addr;
              tail.len   = head.len + req_q.block_size;
              sum_d      = sum_q + req_q.block_size;
            end else if (!full) begin
              tail   = fresh;
              mode_d = M_RIGHT;
              used_d = used_inc;
              if (peak_q < used_inc) peak_d = used_inc;
              sum_d  = sum_q + req_q.block_size;
            end else begin
              status_d = ST_DROPPED;
              lost_n_d = lost_n_q + 32'd1;
              lost_b_d = lost_b_q + req_q.block_size;
            end
          end else if (at_before) begin
            done_d = 1'b1;
            if (head.start + head.len == req_q.block_addr) begin
              tail.len = head.len + req_q.block_size;
              sum_d    = sum_q + req_q.block_size;
              if (next_v && (rel_end == second.start)) begin
                // Join both neighbours and drop the following entry
                tail.len = head.len + req_q.block_size + second.len;
                mode_d   = M_LEFT;
                used_d   = used_q - IdxW'(1);
              end
            end else if (next_v && (rel_end == second.start)) begin
              dly_d.start = req_q.block_addr;
              dly_d.len   = second.len + req_q.block_size;
              mode_d      = M_REPL;
              sum_d       = sum_q + req_q.block_size;
            end else if (!full) begin
              dly_d  = fresh;
              mode_d = M_RIGHT;
              used_d = used_inc;
              if (peak_q < used_inc) peak_d = used_inc;
              sum_d  = sum_q + req_q.block_size;
            end else begin
              status_d = ST_DROPPED;
              lost_n_d = lost_n_q + 32'd1;
              lost_b_d = lost_b_q + req_q.block_size;
            end
          end
        end
      end
    endcase
  end

  assign req_i.ready = state_q == S_IDLE;
  assign rsp_o.valid = state_q == S_OUT;
  always_comb begin
    rsp_o.data.alloc_addr   = addr_q;
    rsp_o.data.status       = status_q;
    rsp_o.data.total_free   = sum_q;
    rsp_o.data.region_count = CountW'(used_q);
    rsp_o.data.peak_count   = CountW'(peak_q);
    rsp_o.data.lost_count   = lost_n_q;
    rsp_o.data.lost_bytes   = lost_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_COPY;
      req_q    <= '0;
      step_q   <= '0;
      n_q      <= '0;
      used_q   <= '0;
      peak_q   <= '0;
      sum_q    <= '0;
      lost_n_q <= '0;
      lost_b_q <= '0;
      addr_q   <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
      dly_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q   <= req_i.data;
            n_q     <= used_q;
            step_q  <= '0;
            mode_q  <= M_COPY;
            done_q  <= 1'b0;
            addr_q  <= '0;
            if (req_i.data.cmd == CMD_ALLOC) status_q <= ST_NO_FIT;
            else status_q <= ST_OK;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          mode_q   <= mode_d;
          dly_q    <= dly_d;
          done_q   <= done_d;
          addr_q   <= addr_d;
          status_q <= status_d;
          sum_q    <= sum_d;
          used_q   <= used_d;
          peak_q   <= peak_d;
          lost_n_q <= lost_n_d;
          lost_b_q <= lost_b_d;
          step_q   <= step_nxt;
          if (step_q == IdxW'(TABLE_ENTRIES - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (rsp_o.ready) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

`include "first_fit_free_list_allocator_macros.svh"

module ffa_checker import ffa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);
  `FFA_ASSERT(a_one_side, clk_i, rst_ni, req_ready_i |-> !rsp_valid_i, "input open while a result waits")
  `FFA_ASSERT_HOLD(a_valid_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result valid dropped")
  `FFA_ASSERT_HOLD(a_data_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_data_i, "result item changed")
  `FFA_ASSERT(a_status_code, clk_i, rst_ni, rsp_valid_i |-> ((rsp_data_i.status == ST_OK) || (rsp_data_i.status == ST_NO_FIT) || (rsp_data_i.status == ST_DROPPED)), "unknown status")
endmodule

bind first_fit_free_list_allocator ffa_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
